>>> rtl/rrt_pkg.sv
// rrt_pkg: beat types, opcodes, status codes and cell command codes
// shared by the request retry tracker cells and top level; no dependencies

package rrt_pkg;

	// opcodes of a request beat
	localparam logic [2:0] OP_ARM   = 3'd0;
	localparam logic [2:0] OP_RESP  = 3'd1;
	localparam logic [2:0] OP_TICK  = 3'd2;
	localparam logic [2:0] OP_DELAY = 3'd3;
	localparam logic [2:0] OP_QUERY = 3'd4;

	// status codes of a response beat
	localparam logic [2:0] ST_ACCEPTED  = 3'd0;
	localparam logic [2:0] ST_INVALID   = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_DONE      = 3'd3;
	localparam logic [2:0] ST_RESEND    = 3'd4;
	localparam logic [2:0] ST_MISMATCH  = 3'd5;
	localparam logic [2:0] ST_UNTRACKED = 3'd6;
	localparam logic [2:0] ST_FOUND     = 3'd7;

	// index width covers the largest supported table
	localparam int IDX_W = 6;
	// results one tick may report
	localparam logic [3:0] MAX_RES = 4'd8;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] msg_id;
		logic [15:0] send_type;
		logic [15:0] resp_type;
		logic [7:0]  retry_limit;
		logic [15:0] period_ticks;
		logic [47:0] dst_mac;
		logic [3:0]  iface_index;
		logic [15:0] context_tag;
		logic        skip_id_check;
	} req_beat_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  entry_index;
		logic [15:0] out_msg_id;
		logic [15:0] out_send_type;
		logic [47:0] out_dst_mac;
		logic [3:0]  out_iface_index;
		logic [15:0] out_context_tag;
		logic        last;
	} rsp_beat_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_ARM,
		CMD_DELAY,
		CMD_FREE,
		CMD_DEC,
		CMD_STOP,
		CMD_SET1
	} cmd_t;

	// control broadcast to every cell
	typedef struct packed {
		cmd_t cmd;
		logic tick_mode;
		logic adv;
	} ctl_t;

	// contents of the selected cell
	typedef struct packed {
		logic             valid;
		logic             is_delay;
		logic             running;
		logic [15:0]      msg_id;
		logic [15:0]      send_type;
		logic [15:0]      resp_type;
		logic [7:0]       tries;
		logic [7:0]       retry_limit;
		logic [15:0]      countdown;
		logic [47:0]      dst_mac;
		logic [3:0]       iface;
		logic [15:0]      tag;
		logic [IDX_W-1:0] idx;
	} rd_t;

	// data handed from one cell to its neighbor
	typedef struct packed {
		logic c_reuse;
		logic c_free;
		logic c_id;
		logic c_rtyp;
		logic tok;
		rd_t  rd;
	} chain_t;

	// first-match flags of one cell
	typedef struct packed {
		logic reuse;
		logic free;
		logic id;
		logic rtyp;
		logic tok;
	} hit_t;

endpackage

>>> rtl/rrt_cell.sv
// rrt_cell: one table entry of the request retry tracker with its share of
// the priority, scan token and read chains; depends on rrt_pkg

module rrt_cell #(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rrt_pkg::req_beat_t req,
	input  rrt_pkg::ctl_t     ctl,
	input  logic              sel_i,
	input  rrt_pkg::chain_t   chain_i,
	output rrt_pkg::chain_t   chain_o,
	output rrt_pkg::hit_t     hit_o
);

	logic        valid_q, is_delay_q, running_q, tok_q;
	logic [15:0] msg_id_q, send_type_q, resp_type_q, countdown_q;
	logic [7:0]  tries_q, retry_limit_q;
	logic [47:0] dest_q;
	logic [3:0]  iface_q;
	logic [15:0] tag_q;

	logic l_reuse, l_free, l_id, l_rtyp, sel;
	rrt_pkg::rd_t my_rd;

	// local matches against the request
	assign l_reuse = valid_q && !is_delay_q && send_type_q == req.send_type
		&& resp_type_q == req.resp_type;
	assign l_free  = !valid_q;
	assign l_id    = valid_q && !is_delay_q && msg_id_q == req.msg_id;
	assign l_rtyp  = valid_q && !is_delay_q && resp_type_q == req.resp_type;

	// first match wins: a carry from lower entries masks this one
	assign hit_o.reuse = l_reuse && !chain_i.c_reuse;
	assign hit_o.free  = l_free && !chain_i.c_free;
	assign hit_o.id    = l_id && !chain_i.c_id;
	assign hit_o.rtyp  = l_rtyp && !chain_i.c_rtyp;
	assign hit_o.tok   = tok_q;

	assign sel = ctl.tick_mode ? tok_q : sel_i;

	// read bus contribution
	always_comb begin
		my_rd.valid       = valid_q;
		my_rd.is_delay    = is_delay_q;
		my_rd.running     = running_q;
		my_rd.msg_id      = msg_id_q;
		my_rd.send_type   = send_type_q;
		my_rd.resp_type   = resp_type_q;
		my_rd.tries       = tries_q;
		my_rd.retry_limit = retry_limit_q;
		my_rd.countdown   = countdown_q;
		my_rd.dst_mac     = dest_q;
		my_rd.iface       = iface_q;
		my_rd.tag         = tag_q;
		my_rd.idx         = rrt_pkg::IDX_W'(IDX);
	end

	// pass carries, token and read bus to the next cell
	always_comb begin
		chain_o.c_reuse = chain_i.c_reuse | l_reuse;
		chain_o.c_free  = chain_i.c_free | l_free;
		chain_o.c_id    = chain_i.c_id | l_id;
		chain_o.c_rtyp  = chain_i.c_rtyp | l_rtyp;
		chain_o.tok     = tok_q;
		chain_o.rd      = chain_i.rd | (sel ? my_rd : '0);
	end

	// scan token shifts one cell per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else if (ctl.adv) begin
			tok_q <= chain_i.tok;
		end
	end

	// entry control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= 1'b0;
			is_delay_q    <= 1'b0;
			running_q     <= 1'b0;
			msg_id_q      <= '0;
			send_type_q   <= '0;
			resp_type_q   <= '0;
			tries_q       <= '0;
			retry_limit_q <= '0;
			countdown_q   <= '0;
		end else if (sel) begin
			case (ctl.cmd)
				rrt_pkg::CMD_ARM: begin
					valid_q       <= 1'b1;
					is_delay_q    <= 1'b0;
					running_q     <= 1'b1;
					msg_id_q      <= req.msg_id;
					send_type_q   <= req.send_type;
					resp_type_q   <= req.resp_type;
					retry_limit_q <= req.retry_limit;
					if (tries_q != 8'hFF) begin
						tries_q <= tries_q + 8'd1;
					end
					countdown_q   <= req.period_ticks;
				end
				rrt_pkg::CMD_DELAY: begin
					valid_q       <= 1'b1;
					is_delay_q    <= 1'b1;
					running_q     <= 1'b1;
					msg_id_q      <= '0;
					send_type_q   <= '0;
					resp_type_q   <= '0;
					tries_q       <= '0;
					retry_limit_q <= '0;
					countdown_q   <= req.period_ticks;
				end
				rrt_pkg::CMD_FREE: begin
					valid_q       <= 1'b0;
					is_delay_q    <= 1'b0;
					running_q     <= 1'b0;
					msg_id_q      <= '0;
					send_type_q   <= '0;
					resp_type_q   <= '0;
					tries_q       <= '0;
					retry_limit_q <= '0;
					countdown_q   <= '0;
				end
				rrt_pkg::CMD_DEC: begin
					countdown_q <= countdown_q - 16'd1;
				end
				rrt_pkg::CMD_STOP: begin
					running_q   <= 1'b0;
					countdown_q <= '0;
				end
				rrt_pkg::CMD_SET1: begin
					countdown_q <= 16'd1;
				end
				default: begin
				end
			endcase
		end
	end

	// payload written on arm and delay only
	always_ff @(posedge clk) begin
		if (sel && ctl.cmd == rrt_pkg::CMD_ARM) begin
			dest_q  <= req.dst_mac;
			iface_q <= req.iface_index;
			tag_q   <= req.context_tag;
		end else if (sel && ctl.cmd == rrt_pkg::CMD_DELAY) begin
			tag_q <= req.context_tag;
		end
	end

endmodule

>>> rtl/request_retry_tracker_core.sv
// request_retry_tracker_core: top level of the request retry tracker, a
// row of rrt_cell entries plus the sequencer; depends on rrt_pkg, rrt_cell
//
// Usage
//   req channel (req_valid/req_ready/req) takes one request beat: arm,
//   response, tick, delayed completion or query. rsp channel
//   (rsp_valid/rsp_ready/rsp) returns the result beats; last marks the
//   final beat caused by a request. A tick with no expiring entry gives
//   no beat at all.
//   One request is worked on at a time. Arm, response, delay, query and
//   unknown opcodes are accepted, then make one search through the cell
//   chain and give one beat. A tick walks a scan token along the cell
//   row one entry per cycle while no held beat is stalled, then the held
//   final beat is sent.
//   The result sits in an output register, so a stalled receiver only
//   holds the block once a further beat must be sent.
//   Reset clears every entry and the sequencer; the block takes a request
//   in the first cycle after reset is released.

module request_retry_tracker_core #(
	parameter int ENTRIES = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  rrt_pkg::req_beat_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output rrt_pkg::rsp_beat_t rsp
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_EXEC  = 4'b0010,
		S_TICK  = 4'b0100,
		S_FLUSH = 4'b1000
	} state_t;

	state_t state_q;
	rrt_pkg::req_beat_t req_q;
	rrt_pkg::rsp_beat_t out_q, pend_q, e_res, t_res, push_data;
	logic out_valid_q, pend_v_q;
	logic [3:0] n_q;

	rrt_pkg::chain_t ch [ENTRIES+1];
	rrt_pkg::hit_t   hit [ENTRIES];
	rrt_pkg::ctl_t   ctl;
	rrt_pkg::rd_t    bus;
	logic [ENTRIES-1:0] sel, tok_vec;
	logic any_reuse, any_free, any_id, any_rtyp;
	logic accept, can_push, push, tok_load;
	rrt_pkg::cmd_t e_cmd, t_cmd;
	logic t_need, stall, t_end;

	assign accept   = req_valid && req_ready;
	assign req_ready = state_q == S_IDLE;
	assign can_push = !out_valid_q || rsp_ready;
	assign tok_load = accept && req.op == rrt_pkg::OP_TICK;

	// head of the chain
	always_comb begin
		ch[0]     = '0;
		ch[0].tok = tok_load;
	end

	// row of entry cells
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		rrt_cell #(.IDX(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.req    (req_q),
			.ctl    (ctl),
			.sel_i  (sel[i]),
			.chain_i(ch[i]),
			.chain_o(ch[i+1]),
			.hit_o  (hit[i])
		);
		assign tok_vec[i] = hit[i].tok;
	end

	assign any_reuse = ch[ENTRIES].c_reuse;
	assign any_free  = ch[ENTRIES].c_free;
	assign any_id    = ch[ENTRIES].c_id;
	assign any_rtyp  = ch[ENTRIES].c_rtyp;
	assign bus       = ch[ENTRIES].rd;

	// entry selection for single-beat ops
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			case (req_q.op)
				rrt_pkg::OP_ARM:   sel[i] = any_reuse ? hit[i].reuse : hit[i].free;
				rrt_pkg::OP_DELAY: sel[i] = hit[i].free;
				rrt_pkg::OP_RESP:  sel[i] = any_id ? hit[i].id : hit[i].rtyp;
				rrt_pkg::OP_QUERY: sel[i] = hit[i].id;
				default:           sel[i] = 1'b0;
			endcase
		end
	end

	// single-beat result and entry command
	always_comb begin
		e_res      = '0;
		e_res.last = 1'b1;
		e_cmd      = rrt_pkg::CMD_NONE;
		case (req_q.op)
			rrt_pkg::OP_ARM: begin
				if (req_q.msg_id == '0 || req_q.resp_type == '0) begin
					e_res.status = rrt_pkg::ST_INVALID;
				end else if (any_reuse || any_free) begin
					e_cmd                 = rrt_pkg::CMD_ARM;
					e_res.status          = rrt_pkg::ST_ACCEPTED;
					e_res.entry_index     = bus.idx[2:0];
					e_res.out_msg_id      = req_q.msg_id;
					e_res.out_send_type   = req_q.send_type;
					e_res.out_context_tag = req_q.context_tag;
				end else begin
					e_res.status = rrt_pkg::ST_FULL;
				end
			end
			rrt_pkg::OP_RESP: begin
				if (any_id) begin
					if (bus.resp_type == req_q.resp_type) begin
						e_cmd                 = rrt_pkg::CMD_FREE;
						e_res.status          = rrt_pkg::ST_DONE;
						e_res.entry_index     = bus.idx[2:0];
						e_res.out_msg_id      = bus.msg_id;
						e_res.out_context_tag = bus.tag;
					end else begin
						e_res.status = rrt_pkg::ST_UNTRACKED;
					end
				end else if (any_rtyp) begin
					e_res.entry_index = bus.idx[2:0];
					e_res.out_msg_id  = bus.msg_id;
					if (req_q.skip_id_check) begin
						e_cmd                 = rrt_pkg::CMD_FREE;
						e_res.status          = rrt_pkg::ST_DONE;
						e_res.out_context_tag = bus.tag;
					end else begin
						e_res.status = rrt_pkg::ST_MISMATCH;
					end
				end else begin
					e_res.status = rrt_pkg::ST_UNTRACKED;
				end
			end
			rrt_pkg::OP_DELAY: begin
				if (any_free) begin
					e_cmd                 = rrt_pkg::CMD_DELAY;
					e_res.status          = rrt_pkg::ST_ACCEPTED;
					e_res.entry_index     = bus.idx[2:0];
					e_res.out_context_tag = req_q.context_tag;
				end else begin
					e_res.status = rrt_pkg::ST_FULL;
				end
			end
			rrt_pkg::OP_QUERY: begin
				if (any_id && bus.resp_type == req_q.resp_type) begin
					e_res.status        = rrt_pkg::ST_FOUND;
					e_res.entry_index   = bus.idx[2:0];
					e_res.out_msg_id    = bus.msg_id;
					e_res.out_send_type = bus.send_type;
				end else begin
					e_res.status = rrt_pkg::ST_UNTRACKED;
				end
			end
			default: begin
				e_res.status = rrt_pkg::ST_INVALID;
			end
		endcase
	end

	// tick: decision for the entry holding the scan token
	always_comb begin
		t_res  = '0;
		t_cmd  = rrt_pkg::CMD_NONE;
		t_need = 1'b0;
		if (bus.valid && bus.running) begin
			if (bus.countdown > 16'd1) begin
				t_cmd = rrt_pkg::CMD_DEC;
			end else if (n_q == rrt_pkg::MAX_RES) begin
				t_cmd = rrt_pkg::CMD_SET1;
			end else begin
				t_need                = 1'b1;
				t_res.entry_index     = bus.idx[2:0];
				t_res.out_msg_id      = bus.msg_id;
				t_res.out_context_tag = bus.tag;
				if (bus.is_delay || bus.tries > bus.retry_limit) begin
					t_cmd        = rrt_pkg::CMD_FREE;
					t_res.status = rrt_pkg::ST_DONE;
				end else begin
					t_cmd               = rrt_pkg::CMD_STOP;
					t_res.status        = rrt_pkg::ST_RESEND;
					t_res.out_send_type = bus.send_type;
					t_res.out_dst_mac   = bus.dst_mac;
					t_res.out_iface_index = bus.iface;
				end
			end
		end
	end

	assign stall = t_need && pend_v_q && !can_push;
	assign t_end = bus.idx == rrt_pkg::IDX_W'(ENTRIES - 1);

	// cell control
	always_comb begin
		ctl.tick_mode = state_q == S_TICK;
		ctl.adv       = tok_load || (state_q == S_TICK && !stall);
		ctl.cmd       = rrt_pkg::CMD_NONE;
		if (state_q == S_EXEC && can_push) begin
			ctl.cmd = e_cmd;
		end else if (state_q == S_TICK && !stall) begin
			ctl.cmd = t_cmd;
		end
	end

	// output register feed
	always_comb begin
		push      = 1'b0;
		push_data = pend_q;
		unique case (state_q)
			S_EXEC: begin
				push      = can_push;
				push_data = e_res;
			end
			S_TICK: begin
				push = !stall && t_need && pend_v_q;
			end
			S_FLUSH: begin
				push           = pend_v_q && can_push;
				push_data.last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pend_v_q <= 1'b0;
			n_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						pend_v_q <= 1'b0;
						n_q      <= '0;
						state_q  <= (req.op == rrt_pkg::OP_TICK) ? S_TICK : S_EXEC;
					end
				end
				S_EXEC: begin
					if (can_push) begin
						state_q <= S_IDLE;
					end
				end
				S_TICK: begin
					if (!stall) begin
						if (t_need) begin
							pend_v_q <= 1'b1;
							n_q      <= n_q + 4'd1;
						end
						if (t_end) begin
							state_q <= S_FLUSH;
						end
					end
				end
				S_FLUSH: begin
					if (!pend_v_q || can_push) begin
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request and held tick beat
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (state_q == S_TICK && !stall && t_need) begin
			pend_q <= t_res;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= push_data;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

`ifndef ASSERT_OFF
	a_tok_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec))
		else $error("more than one cell holds the scan token");

	a_tok_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TICK |-> $onehot(tok_vec))
		else $error("tick scan without a token");

	a_sel_single: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC |-> $onehot0(sel))
		else $error("search selected more than one entry");

	a_tick_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= rrt_pkg::MAX_RES)
		else $error("tick reported too many beats");

	a_exec_push: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC && can_push |=> rsp_valid && rsp.last)
		else $error("single-beat op gave no final beat");
`endif

endmodule
